### hdl/qdec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdec_pkg
// Shared types, constants and the quadrature table of the decoder.
// ----------------------------------------------------------------------------
package qdec_pkg;

  localparam int NumEncoders = 2;
  localparam int IdxW        = 1;
  localparam int PinW        = 2;
  localparam int HistW       = 4;
  localparam int AccW        = 8;
  localparam int TimeW       = 32;
  localparam int ThrW        = 16;
  localparam int StepW       = 8;
  localparam int CfgIdxW     = 2;

  localparam logic [ThrW-1:0] SlowThrRst   = 16'd500;
  localparam logic [ThrW-1:0] MediumThrRst = 16'd200;
  localparam logic [ThrW-1:0] FastThrRst   = 16'd50;

  localparam logic signed [AccW-1:0] AccMax = 8'sd127;
  localparam logic signed [AccW-1:0] AccMin = -8'sd127;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSlow   = 2'd0,
    CfgMedium = 2'd1,
    CfgFast   = 2'd2
  } cfg_reg_e;

  localparam logic signed [1:0] QuadTable [16] = '{
    2'sd0, 2'sd1, -2'sd1, 2'sd0, -2'sd1, 2'sd0, 2'sd0, 2'sd1,
    2'sd1, 2'sd0, 2'sd0, -2'sd1, 2'sd0, -2'sd1, 2'sd1, 2'sd0
  };

  typedef struct packed {
    logic [HistW-1:0]       hist;
    logic signed [AccW-1:0] acc;
    logic [TimeW-1:0]       last_ms;
  } lane_state_t;

  typedef struct packed {
    logic [ThrW-1:0] slow;
    logic [ThrW-1:0] mid;
    logic [ThrW-1:0] fast;
  } thr_t;

  typedef struct packed {
    logic                    emit;
    logic signed [StepW-1:0] steps;
    lane_state_t             next;
  } step_res_t;

endpackage
`default_nettype wire

### hdl/qdec_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdec_lane
// Per-encoder state: pin history, microstep sum and last event time.
// Gives its state masked by its select, for an OR-based lane mux.
// ----------------------------------------------------------------------------
module qdec_lane (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  sel_i,
  input  logic                  wr_i,
  input  qdec_pkg::lane_state_t next_i,
  output qdec_pkg::lane_state_t state_o,
  output qdec_pkg::lane_state_t masked_o
);
  import qdec_pkg::*;

  lane_state_t st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (wr_i) begin
      st_q <= next_i;
    end
  end

  assign state_o  = st_q;
  assign masked_o = sel_i ? st_q : '0;

endmodule
`default_nettype wire

### hdl/qdec_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdec_step
// One sample update: table lookup, saturating accumulate, event check,
// divide by four toward zero, speed multiplier and step saturation.
// ----------------------------------------------------------------------------
module qdec_step (
  input  logic                       [qdec_pkg::PinW-1:0]  pins_i,
  input  logic                                             last_i,
  input  logic                       [qdec_pkg::TimeW-1:0] now_i,
  input  qdec_pkg::lane_state_t                            state_i,
  input  qdec_pkg::thr_t                                   thr_i,
  output qdec_pkg::step_res_t                              res_o
);
  import qdec_pkg::*;

  localparam int WideW = StepW + 3;

  logic [HistW-1:0]        hist;
  logic signed [1:0]       delta;
  logic signed [AccW:0]    acc_sum;
  logic signed [AccW-1:0]  sum;
  logic signed [AccW-1:0]  bias;
  logic signed [AccW-1:0]  quot;
  logic signed [AccW-1:0]  rem;
  logic [TimeW-1:0]        interval;
  logic [1:0]              shamt;
  logic signed [WideW-1:0] wide;
  logic signed [StepW-1:0] steps;
  logic                    emit;

  always_comb begin
    hist    = {state_i.hist[HistW-PinW-1:0], pins_i};
    delta   = QuadTable[hist];
    acc_sum = {state_i.acc[AccW-1], state_i.acc} + {{(AccW-1){delta[1]}}, delta};
    if (acc_sum > (AccW+1)'(AccMax)) begin
      sum = AccMax;
    end else if (acc_sum < (AccW+1)'(AccMin)) begin
      sum = AccMin;
    end else begin
      sum = acc_sum[AccW-1:0];
    end

    emit = last_i && ((sum > 8'sd3) || (sum < -8'sd3));

    bias = sum[AccW-1] ? 8'sd3 : 8'sd0;
    quot = (sum + bias) >>> 2;
    rem  = sum - (quot <<< 2);

    interval = now_i - state_i.last_ms;
    if (interval > {{(TimeW-ThrW){1'b0}}, thr_i.slow}) begin
      shamt = 2'd0;
    end else if (interval > {{(TimeW-ThrW){1'b0}}, thr_i.mid}) begin
      shamt = 2'd1;
    end else if (interval > {{(TimeW-ThrW){1'b0}}, thr_i.fast}) begin
      shamt = 2'd2;
    end else begin
      shamt = 2'd3;
    end

    wide = {{(WideW-AccW){quot[AccW-1]}}, quot} <<< shamt;
    if (wide > WideW'(AccMax)) begin
      steps = AccMax;
    end else if (wide < WideW'(AccMin)) begin
      steps = AccMin;
    end else begin
      steps = wide[StepW-1:0];
    end

    res_o.emit         = emit;
    res_o.steps        = steps;
    res_o.next.hist    = hist;
    res_o.next.acc     = emit ? rem : sum;
    res_o.next.last_ms = emit ? now_i : state_i.last_ms;
  end

endmodule
`default_nettype wire

### hdl/quadrature_decoder_with_acceleration.sv
// Pipeline: two register stages, an input register and then a result register
// that takes only the requests that raise a step event.
// Throughput: one request per cycle, unless an event request waits on a full,
// stalled result register; the per-encoder state is read, updated and written
// back by the logic between the two registers. Reset: clears all encoder state
// and both stages; thresholds go to 500, 200 and 50 ms.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadrature_decoder_with_acceleration
// Multi-encoder quadrature decoder with speed-dependent step scaling.
// ----------------------------------------------------------------------------
module quadrature_decoder_with_acceleration #(
  parameter int NUM_ENCODERS = qdec_pkg::NumEncoders
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [qdec_pkg::IdxW-1:0]            encoder_index_i,
  input  logic [qdec_pkg::PinW-1:0]            pin_pair_i,
  input  logic                                 batch_end_i,
  input  logic [qdec_pkg::TimeW-1:0]           now_ms_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [qdec_pkg::IdxW-1:0]            event_encoder_o,
  output logic signed [qdec_pkg::StepW-1:0]    step_count_o,
  input  logic                                 cfg_we_i,
  input  logic [qdec_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [qdec_pkg::ThrW-1:0]            cfg_wdata_i
);
  import qdec_pkg::*;

  localparam int LaneCmpW = $clog2(NUM_ENCODERS) + 1;

  thr_t thr_q;

  logic              in_valid_q;
  logic [IdxW-1:0]   in_idx_q;
  logic [PinW-1:0]   in_pins_q;
  logic              in_last_q;
  logic [TimeW-1:0]  in_now_q;

  logic                    res_valid_q;
  logic [IdxW-1:0]         res_idx_q;
  logic signed [StepW-1:0] res_steps_q;

  logic [NUM_ENCODERS-1:0] hit;
  lane_state_t             lane_st  [NUM_ENCODERS];
  lane_state_t             lane_msk [NUM_ENCODERS];
  lane_state_t             sel_st;
  step_res_t               step;
  logic                    in_range;
  logic                    emit;
  logic                    fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.slow <= SlowThrRst;
      thr_q.mid  <= MediumThrRst;
      thr_q.fast <= FastThrRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgSlow:   thr_q.slow <= cfg_wdata_i;
        CfgMedium: thr_q.mid  <= cfg_wdata_i;
        CfgFast:   thr_q.fast <= cfg_wdata_i;
        default:   thr_q      <= thr_q;
      endcase
    end
  end

  for (genvar e = 0; e < NUM_ENCODERS; e++) begin : g_lane
    assign hit[e] = in_valid_q && (LaneCmpW'(in_idx_q) == LaneCmpW'(e));

    qdec_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .sel_i    (hit[e]),
      .wr_i     (fire && hit[e]),
      .next_i   (step.next),
      .state_o  (lane_st[e]),
      .masked_o (lane_msk[e])
    );
  end

  always_comb begin
    sel_st = '0;
    for (int e = 0; e < NUM_ENCODERS; e++) begin
      sel_st = sel_st | lane_msk[e];
    end
  end

  qdec_step u_step (
    .pins_i  (in_pins_q),
    .last_i  (in_last_q),
    .now_i   (in_now_q),
    .state_i (sel_st),
    .thr_i   (thr_q),
    .res_o   (step)
  );

  assign in_range   = |hit;
  assign emit       = in_range && step.emit;
  assign fire       = in_valid_q && (!emit || !res_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_idx_q  <= encoder_index_i;
      in_pins_q <= pin_pair_i;
      in_last_q <= batch_end_i;
      in_now_q  <= now_ms_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (fire && emit) begin
      res_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      res_idx_q   <= in_idx_q;
      res_steps_q <= step.steps;
    end
  end

  assign out_valid_o     = res_valid_q;
  assign event_encoder_o = res_idx_q;
  assign step_count_o    = res_steps_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && emit) |=> out_valid_o)
    else $error("event request did not reach the result register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (step_count_o != 8'sd0))
    else $error("result with zero steps");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && emit && hit[0]) |=>
      ((lane_st[0].acc < 8'sd4) && (lane_st[0].acc > -8'sd4)))
    else $error("accumulator remainder out of range after event");

endmodule
`default_nettype wire

### verif/quadrature_decoder_with_acceleration_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_decoder_with_acceleration_test
// Self-checking bench for the quadrature decoder. A short directed table runs
// first. Random encoder turns, long spins and pin noise follow, under six
// threshold settings. A behavioral predictor (the table's pinned rows give their
// own results) checks every step event; both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module quadrature_decoder_with_acceleration_test;
  import qdec_pkg::*;

  localparam int ClkHalf     = 2;
  localparam int PhaseItems  = 30;
  localparam int DrainCycles = 4;
  localparam int LimitNs     = 4_000_000;

  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  localparam int MicroStep [16] = '{0, 1, -1, 0, -1, 0, 0, 1, 1, 0, 0, -1, 0, -1, 1, 0};
  localparam logic [PinW-1:0] CwNext  [4] = '{2'b01, 2'b11, 2'b00, 2'b10};
  localparam logic [PinW-1:0] CcwNext [4] = '{2'b10, 2'b00, 2'b11, 2'b01};

  typedef struct packed {
    logic [IdxW-1:0]         enc;
    logic signed [StepW-1:0] steps;
  } step_event_t;

  typedef struct {
    logic [IdxW-1:0]  enc;
    logic [PinW-1:0]  pins;
    bit               last;
    logic [TimeW-1:0] now;
    bit               pinned;
    bit               fires;
    step_event_t      want;
  } sample_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [IdxW-1:0]         encoder_index;
  logic [PinW-1:0]         pin_pair;
  logic                    batch_end;
  logic [TimeW-1:0]        now_ms;
  logic                    out_valid;
  logic                    out_stall;
  logic [IdxW-1:0]         event_encoder;
  logic signed [StepW-1:0] step_count;
  logic                    cfg_we;
  logic [CfgIdxW-1:0]      cfg_index;
  logic [ThrW-1:0]         cfg_wdata;

  logic [HistW-1:0] pin_hist [NumEncoders];
  int               microsteps [NumEncoders];
  logic [TimeW-1:0] event_ms [NumEncoders];
  thr_t             thr;

  step_event_t pending_events [$];
  int samples_sent   = 0;
  int events_checked = 0;
  int mismatches     = 0;
  int send_calm      = 0;
  int recv_calm      = 0;

  sample_row_t directed_rows [22] = '{
    '{1'b0, 2'b01, 1'b1, 32'd0,          1'b1, 1'b0, '{1'b0, 8'sd0}},
    '{1'b0, 2'b11, 1'b0, 32'd0,          1'b0, 1'b0, '{1'b0, 8'sd0}},
    '{1'b0, 2'b10, 1'b0, 32'd0,          1'b0, 1'b0, '{1'b0, 8'sd0}},
    '{1'b0, 2'b00, 1'b1, 32'd1000,       1'b1, 1'b1, '{1'b0, 8'sd1}},
    '{1'b0, 2'b00, 1'b1, 32'd1001,       1'b1, 1'b0, '{1'b0, 8'sd0}},
    '{1'b0, 2'b11, 1'b0, 32'd1001,       1'b0, 1'b0, '{1'b0, 8'sd0}},
    '{1'b0, 2'b10, 1'b0, 32'd1001,       1'b0, 1'b0, '{1'b0, 8'sd0}},
    '{1'b0, 2'b00, 1'b0, 32'd1001,       1'b0, 1'b0, '{1'b0, 8'sd0}},
    '{1'b0, 2'b01, 1'b0, 32'd1001,       1'b0, 1'b0, '{1'b0, 8'sd0}},
    '{1'b0, 2'b11, 1'b1, 32'd1300,       1'b1, 1'b1, '{1'b0, 8'sd2}},
    '{1'b1, 2'b10, 1'b0, 32'd0,          1'b0, 1'b0, '{1'b0, 8'sd0}},
    '{1'b1, 2'b11, 1'b0, 32'd0,          1'b0, 1'b0, '{1'b0, 8'sd0}},
    '{1'b1, 2'b01, 1'b0, 32'd0,          1'b0, 1'b0, '{1'b0, 8'sd0}},
    '{1'b1, 2'b00, 1'b1, 32'hFFFF_FFFF,  1'b1, 1'b1, '{1'b1, -8'sd1}},
    '{1'b1, 2'b10, 1'b0, 32'hFFFF_FFFF,  1'b0, 1'b0, '{1'b0, 8'sd0}},
    '{1'b1, 2'b11, 1'b0, 32'hFFFF_FFFF,  1'b0, 1'b0, '{1'b0, 8'sd0}},
    '{1'b1, 2'b01, 1'b0, 32'hFFFF_FFFF,  1'b0, 1'b0, '{1'b0, 8'sd0}},
    '{1'b1, 2'b00, 1'b1, 32'd48,         1'b1, 1'b1, '{1'b1, -8'sd8}},
    '{1'b0, 2'b10, 1'b0, 32'd1400,       1'b0, 1'b0, '{1'b0, 8'sd0}},
    '{1'b0, 2'b00, 1'b0, 32'd1400,       1'b0, 1'b0, '{1'b0, 8'sd0}},
    '{1'b0, 2'b01, 1'b0, 32'd1400,       1'b0, 1'b0, '{1'b0, 8'sd0}},
    '{1'b0, 2'b11, 1'b1, 32'd1400,       1'b1, 1'b1, '{1'b0, 8'sd4}}
  };

  quadrature_decoder_with_acceleration i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .encoder_index_i (encoder_index),
    .pin_pair_i      (pin_pair),
    .batch_end_i     (batch_end),
    .now_ms_i        (now_ms),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .event_encoder_o (event_encoder),
    .step_count_o    (step_count),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #ClkHalf clk = ~clk;
  end

  function automatic int clamp127(input int v);
    if (v > 127) return 127;
    if (v < -127) return -127;
    return v;
  endfunction

  function automatic bit decode_sample(input logic [IdxW-1:0] enc, input logic [PinW-1:0] pins,
                                       input bit last, input logic [TimeW-1:0] now,
                                       output logic signed [StepW-1:0] steps);
    logic [TimeW-1:0] span;
    int sum;
    int scale;
    steps = '0;
    pin_hist[enc] = {pin_hist[enc][1:0], pins};
    sum = clamp127(microsteps[enc] + MicroStep[pin_hist[enc]]);
    microsteps[enc] = sum;
    if (!last || (sum > -4 && sum < 4)) return 1'b0;
    span = now - event_ms[enc];
    if (span > TimeW'(thr.slow)) scale = 1;
    else if (span > TimeW'(thr.mid)) scale = 2;
    else if (span > TimeW'(thr.fast)) scale = 4;
    else scale = 8;
    steps = StepW'(clamp127((sum / 4) * scale));
    microsteps[enc] = sum % 4;
    event_ms[enc] = now;
    return 1'b1;
  endfunction

  function automatic int pick_gap(inout int calm);
    int roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [TimeW-1:0] pick_end_ms(input logic [IdxW-1:0] enc);
    logic [TimeW-1:0] span;
    logic [ThrW-1:0]  knee;
    case ($urandom_range(0, 5))
      0: span = $urandom_range(0, 60);
      1, 2: begin
        case ($urandom_range(0, 2))
          0: knee = thr.slow;
          1: knee = thr.mid;
          default: knee = thr.fast;
        endcase
        span = TimeW'(knee) + $urandom_range(0, 2) - 1;
      end
      3: span = $urandom_range(0, 70000);
      4: span = $urandom();
      default: return $urandom();
    endcase
    return event_ms[enc] + span;
  endfunction

  task automatic send_sample(input logic [IdxW-1:0] enc, input logic [PinW-1:0] pins,
                             input bit last, input logic [TimeW-1:0] now,
                             input bit pinned = 1'b0, input bit fires = 1'b0,
                             input step_event_t want = '0);
    int gap;
    bit hit;
    logic signed [StepW-1:0] steps;
    gap = pick_gap(send_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    encoder_index <= enc;
    pin_pair      <= pins;
    batch_end     <= last;
    now_ms        <= now;
    do @(posedge clk); while (in_stall);
    hit = decode_sample(enc, pins, last, now, steps);
    if (pinned) begin
      if (fires) pending_events.push_back(want);
    end else if (hit) begin
      pending_events.push_back('{enc, steps});
    end
    samples_sent++;
  endtask

  // A clean turn has no noise and ends at most 100 ms after the last event.
  task automatic spin_encoder(input logic [IdxW-1:0] enc, input bit cw, input int count,
                              input bit clean);
    logic [PinW-1:0]  pins;
    logic [TimeW-1:0] now;
    bit last;
    for (int k = 0; k < count; k++) begin
      pins = pin_hist[enc][1:0];
      case (clean ? 2 : $urandom_range(0, 19))
        0: pins = pins;
        1: pins = ~pins;
        default: pins = cw ? CwNext[pins] : CcwNext[pins];
      endcase
      last = (k == count - 1) || (!clean && $urandom_range(0, 9) == 0);
      if (!last) now = $urandom();
      else if (clean) now = event_ms[enc] + $urandom_range(0, 100);
      else now = pick_end_ms(enc);
      send_sample(enc, pins, last, now);
    end
  endtask

  task automatic run_random(input int quota);
    int start;
    start = samples_sent;
    while (samples_sent - start < quota) begin
      if ($urandom_range(0, 99) < 80) begin
        spin_encoder(IdxW'($urandom()), 1'($urandom_range(0, 1)),
                     ($urandom_range(0, 49) == 0) ? $urandom_range(130, 150)
                                                  : $urandom_range(1, 12), 1'b0);
      end else begin
        repeat ($urandom_range(1, 4))
          send_sample(IdxW'($urandom()), PinW'($urandom()), 1'($urandom_range(0, 1)),
                      $urandom());
      end
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ThrW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CfgSlow:   thr.slow = data;
      CfgMedium: thr.mid  = data;
      CfgFast:   thr.fast = data;
      default: ;
    endcase
  endtask

  // Drain all requests before touching the thresholds.
  task automatic reprogram(input logic [ThrW-1:0] slow, input logic [ThrW-1:0] mid,
                           input logic [ThrW-1:0] fast, input bit poke_spare);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(negedge clk);
    write_reg(CfgSlow, slow);
    write_reg(CfgMedium, mid);
    write_reg(CfgFast, fast);
    if (poke_spare) write_reg(CfgSpare, ThrW'($urandom()));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = pick_gap(recv_calm);
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_events
    step_event_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        mismatches++;
        $error("unexpected step event: event_encoder %0d, step_count %0d",
               event_encoder, step_count);
      end else begin
        want = pending_events.pop_front();
        events_checked++;
        if (event_encoder !== want.enc) begin
          mismatches++;
          $error("event_encoder mismatch: expected %0d, got %0d", want.enc, event_encoder);
        end
        if (step_count !== want.steps) begin
          mismatches++;
          $error("step_count mismatch: expected %0d, got %0d", want.steps, step_count);
        end
      end
    end
  end

  initial begin
    #LimitNs;
    $display("quadrature_decoder_with_acceleration test failed");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    encoder_index = '0;
    pin_pair      = '0;
    batch_end     = 1'b0;
    now_ms        = '0;
    cfg_we        = 1'b0;
    cfg_index     = CfgSlow;
    cfg_wdata     = '0;
    for (int e = 0; e < NumEncoders; e++) begin
      pin_hist[e]   = '0;
      microsteps[e] = 0;
      event_ms[e]   = '0;
    end
    thr = '{slow: SlowThrRst, mid: MediumThrRst, fast: FastThrRst};
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_sample(directed_rows[i].enc, directed_rows[i].pins, directed_rows[i].last,
                  directed_rows[i].now, directed_rows[i].pinned, directed_rows[i].fires,
                  directed_rows[i].want);
    run_random(PhaseItems);

    // Saturate both accumulators and both step counts.
    reprogram(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    spin_encoder(1'b0, 1'b1, 140, 1'b1);
    spin_encoder(1'b1, 1'b0, 140, 1'b1);
    run_random(PhaseItems);

    reprogram(16'h0000, 16'h0000, 16'h0000, 1'b0);
    run_random(PhaseItems);

    reprogram(16'd10, 16'd1000, 16'd5000, 1'b1);
    run_random(PhaseItems);

    reprogram(ThrW'($urandom_range(0, 600)), ThrW'($urandom_range(0, 600)),
              ThrW'($urandom_range(0, 600)), 1'b0);
    run_random(PhaseItems);

    reprogram(ThrW'($urandom()), ThrW'($urandom()), ThrW'($urandom()), 1'b0);
    run_random(PhaseItems);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d pin samples across six threshold settings; %0d step events checked.",
             samples_sent, events_checked);
    $display("Mismatches found: %0d", mismatches);
    if (mismatches == 0) begin
      $display("quadrature_decoder_with_acceleration test passed");
    end else begin
      $display("quadrature_decoder_with_acceleration test failed");
    end
    $finish;
  end

endmodule
